// ----- sv/jsw_pkg.sv -----
// shared widths, constants and codes for the jacobi seven-point sweep block
package jsw_pkg;

  // payload widths
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 18;
  localparam int EDGE_IN_W = 7;

  // grid size defaults
  localparam int MAX_EDGE_DEF = 64;
  localparam int EDGE_RESET   = 64;
  localparam int EDGE_MIN     = 3;

  // configuration port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_EDGE = REG_IDX_W'(0);

  // arithmetic: Q8.24 values, Q16.48 stencil sum
  localparam int FRAC_W = 24;
  localparam int NB_W   = DATA_W + 3;
  localparam int SUM_W  = 2 * DATA_W;

  // rounding and scaling: quotient = ((|s| + 3*2^24) >> 25) / 3
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd3 << FRAC_W);
  localparam int SHIFT_W = FRAC_W + 1;
  localparam int U_W     = SUM_W - SHIFT_W;
  localparam logic [U_W-1:0] SAT_POS = U_W'(64'd3 * 64'h8000_0000);
  localparam logic [U_W-1:0] SAT_NEG = U_W'(64'd3 * 64'h8000_0001);

  // divide-by-three unit: dividend bits and bits retired per cycle
  localparam int QIN_W     = 33;
  localparam int DIV_W     = 40;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

endpackage

// ----- sv/jsw_in_if.sv -----
// input stream channel: old grid value and source weight per raster point
interface jsw_in_if import jsw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] old_value;
  logic signed [DATA_W-1:0] source_weight;

  modport source (output valid, old_value, source_weight, input ready);
  modport sink   (input valid, old_value, source_weight, output ready);
endinterface

// ----- sv/jsw_out_if.sv -----
// result stream channel: updated interior value with its linear index
interface jsw_out_if import jsw_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_value;
  logic [IDX_W-1:0]         point_index;
  logic                     sweep_done;

  modport source (output valid, new_value, point_index, sweep_done, input ready);
  modport sink   (input valid, new_value, point_index, sweep_done, output ready);
endinterface

// ----- sv/jsw_scale.sv -----
// multi-cycle scaling unit: divide by 6*2^24, round half away from zero, saturate
module jsw_scale import jsw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [SUM_W-1:0]  sum,
  output logic                     done,
  output logic signed [DATA_W-1:0] value
);

  typedef enum logic [4:0] {
    SC_IDLE  = 5'b00001,
    SC_ABS   = 5'b00010,
    SC_RANGE = 5'b00100,
    SC_DIV   = 5'b01000,
    SC_FIN   = 5'b10000
  } scale_state_t;

  scale_state_t          state;
  logic [SUM_W-1:0]      sum_r;
  logic                  neg;
  logic [SUM_W-1:0]      mag;
  logic                  sat;
  logic [DIV_W-1:0]      dvd;
  logic [DIV_W-1:0]      quo;
  logic [1:0]            rem;
  logic [DIV_CNT_W-1:0]  cnt;

  logic [SUM_W-1:0]      rounded;
  logic [U_W-1:0]        u_val;
  logic [DIV_BITS-1:0]   qbits;
  logic [1:0]            rem_next;
  logic [DATA_W-1:0]     q32;

  // rounding offset and magnitude before the divide
  assign rounded = mag + ROUND_HALF;
  assign u_val   = rounded[SUM_W-1:SHIFT_W];
  assign q32     = quo[DATA_W-1:0];

  // one radix-2 restoring step per dividend bit, DIV_BITS bits per cycle
  always_comb begin
    logic [2:0] t3;
    logic [1:0] r;
    r     = rem;
    qbits = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t3 = {r, dvd[DIV_W-1-i]};
      if (t3 >= 3'd3) begin
        qbits[DIV_BITS-1-i] = 1'b1;
        r = 2'(t3 - 3'd3);
      end else begin
        r = t3[1:0];
      end
    end
    rem_next = r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= (state == SC_FIN);
      case (state)
        SC_IDLE: begin
          if (start) begin
            state <= SC_ABS;
          end
        end
        SC_ABS: begin
          state <= SC_RANGE;
        end
        SC_RANGE: begin
          cnt   <= '0;
          state <= SC_DIV;
        end
        SC_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= SC_FIN;
          end
        end
        SC_FIN: begin
          state <= SC_IDLE;
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          sum_r <= sum;
        end
      end
      SC_ABS: begin
        neg <= sum_r[SUM_W-1];
        mag <= sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
      end
      SC_RANGE: begin
        sat <= neg ? (u_val >= SAT_NEG) : (u_val >= SAT_POS);
        dvd <= DIV_W'(u_val[QIN_W-1:0]);
        quo <= '0;
        rem <= 2'd0;
      end
      SC_DIV: begin
        dvd <= dvd << DIV_BITS;
        quo <= {quo[DIV_W-DIV_BITS-1:0], qbits};
        rem <= rem_next;
      end
      SC_FIN: begin
        if (sat) begin
          value <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          value <= neg ? signed'(~q32 + 1'b1) : signed'(q32);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/jacobi_3d_seven_point_sweep_top.sv -----
// top level: streaming seven-point jacobi sweep over a cubic grid
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------
//  sample    | in  | valid/ready           | old_value, source_weight
//  result    | out | valid/ready           | new_value, point_index, sweep_done
//  apb       | in  | psel/penable, pready  | grid_edge at byte address 0
//
// a boundary point is written to the plane ring as it is accepted.
// an interior point is handled in steps: six reads through the single plane-ring
// read port, multiply and sum, then the iterative divide by three in the scaling unit.
// rst is synchronous; it clears the raster counters and sets grid_edge to its default.
// a waiting result sits in the output register; only the next push stalls on it.
module jacobi_3d_seven_point_sweep_top import jsw_pkg::*; #(
  parameter int MAX_EDGE = MAX_EDGE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  jsw_in_if.sink             sample,
  jsw_out_if.source          result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int PLANE_WORDS = MAX_EDGE * MAX_EDGE;
  localparam int RING_DEPTH  = 2 * PLANE_WORDS;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int WT_AW       = $clog2(PLANE_WORDS);
  localparam int CNT_W       = $clog2(MAX_EDGE);
  localparam int EDGE_W      = $clog2(MAX_EDGE + 1);
  localparam int CW          = EDGE_W + 1;
  localparam int EDGE_RST    = (EDGE_RESET > MAX_EDGE) ? MAX_EDGE :
                               ((EDGE_RESET < EDGE_MIN) ? EDGE_MIN : EDGE_RESET);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_PUSH  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    RD_CENTRE = 3'd0,
    RD_WEST   = 3'd1,
    RD_EAST   = 3'd2,
    RD_NORTH  = 3'd3,
    RD_SOUTH  = 3'd4,
    RD_PREV   = 3'd5
  } rd_step_t;

  // plane ring and source weight delay
  logic [DATA_W-1:0] ring [RING_DEPTH];
  logic [DATA_W-1:0] wdel [PLANE_WORDS];

  state_t                    state;
  rd_step_t                  rd_step;
  rd_step_t                  rd_tag;
  logic                      rd_live;

  logic [CNT_W-1:0]          plane_cnt;
  logic [CNT_W-1:0]          row_cnt;
  logic [CNT_W-1:0]          col_cnt;
  logic [EDGE_W-1:0]         edge_len;
  logic [IDX_W-1:0]          edge_sq;
  logic [IDX_W-1:0]          lin;

  logic signed [DATA_W-1:0]  cur_val;
  logic signed [DATA_W-1:0]  wgt_val;
  logic                      pos_slot;
  logic [CNT_W-1:0]          pos_row;
  logic [CNT_W-1:0]          pos_col;
  logic                      pos_done;
  logic [IDX_W-1:0]          pos_index;

  logic signed [DATA_W-1:0]  ring_q;
  logic signed [DATA_W-1:0]  wt_q;
  logic signed [DATA_W-1:0]  centre;
  logic signed [NB_W-1:0]    nb;
  logic signed [SUM_W-1:0]   prod;

  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_value;
  logic [IDX_W-1:0]          out_index;
  logic                      out_done;

  logic                      accept;
  logic                      cfg_wr;
  logic [CW-1:0]             qe, re, ce, ee;
  logic                      interior_now;
  logic                      done_now;
  logic                      c_last, r_last, q_last;
  logic [31:0]               edge_pick;
  logic [EDGE_W-1:0]         edge_next;
  logic [2*EDGE_W-1:0]       sq_next;

  logic                      rd_en, wt_rd_en;
  logic                      rd_slot;
  logic [CNT_W-1:0]          rd_row, rd_col;
  logic [RING_AW-1:0]        rd_ring_addr;
  logic [WT_AW-1:0]          rd_wt_addr;
  logic                      wr_en;
  logic                      wr_slot;
  logic [CNT_W-1:0]          wr_row, wr_col;
  logic [DATA_W-1:0]         wr_data, wr_wgt;
  logic [RING_AW-1:0]        wr_ring_addr;
  logic [WT_AW-1:0]          wr_wt_addr;

  logic signed [SUM_W-1:0]   stencil_sum;
  logic                      scale_done;
  logic signed [DATA_W-1:0]  scale_value;

  function automatic logic [RING_AW-1:0] ring_addr(input logic slot,
                                                   input logic [CNT_W-1:0] row,
                                                   input logic [CNT_W-1:0] col);
    logic [31:0] a;
    a = (slot ? 32'(PLANE_WORDS) : 32'd0) + 32'(row) * 32'(MAX_EDGE) + 32'(col);
    return RING_AW'(a);
  endfunction

  function automatic logic [WT_AW-1:0] plane_addr(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
    logic [31:0] a;
    a = 32'(row) * 32'(MAX_EDGE) + 32'(col);
    return WT_AW'(a);
  endfunction

  // handshakes
  assign sample.ready = (state == S_IDLE) && !rst;
  assign accept       = sample.valid && sample.ready;
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_GRID_EDGE);
  assign prdata       = (paddr[PADDR_W-1:2] == REG_GRID_EDGE) ? PDATA_W'(edge_len) : '0;

  assign result.valid       = out_valid;
  assign result.new_value   = out_value;
  assign result.point_index = out_index;
  assign result.sweep_done  = out_done;

  // raster position tests
  assign qe = CW'(plane_cnt);
  assign re = CW'(row_cnt);
  assign ce = CW'(col_cnt);
  assign ee = CW'(edge_len);
  assign interior_now = (qe >= CW'(2)) && (re >= CW'(1)) && (re + CW'(1) < ee) &&
                        (ce >= CW'(1)) && (ce + CW'(1) < ee);
  assign done_now = (qe + CW'(1) == ee) && (re + CW'(2) == ee) && (ce + CW'(2) == ee);
  assign c_last   = !(ce + CW'(1) < ee);
  assign r_last   = !(re + CW'(1) < ee);
  assign q_last   = !(qe + CW'(1) < ee);

  // edge clamp on a register write
  always_comb begin
    edge_pick = 32'(pwdata[EDGE_IN_W-1:0]);
    if (edge_pick < 32'(EDGE_MIN)) begin
      edge_pick = 32'(EDGE_MIN);
    end else if (edge_pick > 32'(MAX_EDGE)) begin
      edge_pick = 32'(MAX_EDGE);
    end
  end
  assign edge_next = EDGE_W'(edge_pick);
  assign sq_next   = (2*EDGE_W)'(edge_next) * (2*EDGE_W)'(edge_next);

  // read address for the current stencil tap
  always_comb begin
    rd_slot = ~pos_slot;
    rd_row  = pos_row;
    rd_col  = pos_col;
    case (rd_step)
      RD_CENTRE: begin
      end
      RD_WEST:   rd_col = pos_col - 1'b1;
      RD_EAST:   rd_col = pos_col + 1'b1;
      RD_NORTH:  rd_row = pos_row - 1'b1;
      RD_SOUTH:  rd_row = pos_row + 1'b1;
      RD_PREV:   rd_slot = pos_slot;
      default: begin
      end
    endcase
  end
  assign rd_en        = (state == S_READ);
  assign wt_rd_en     = rd_en && (rd_step == RD_CENTRE);
  assign rd_ring_addr = ring_addr(rd_slot, rd_row, rd_col);
  assign rd_wt_addr   = plane_addr(pos_row, pos_col);

  // write port: boundary points at accept, interior points after their reads
  assign wr_en        = (accept && !interior_now && !cfg_wr) || (state == S_MUL);
  assign wr_slot      = (state == S_MUL) ? pos_slot : plane_cnt[0];
  assign wr_row       = (state == S_MUL) ? pos_row : row_cnt;
  assign wr_col       = (state == S_MUL) ? pos_col : col_cnt;
  assign wr_data      = (state == S_MUL) ? cur_val : sample.old_value;
  assign wr_wgt       = (state == S_MUL) ? wgt_val : sample.source_weight;
  assign wr_ring_addr = ring_addr(wr_slot, wr_row, wr_col);
  assign wr_wt_addr   = plane_addr(wr_row, wr_col);

  // memories
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_ring_addr] <= wr_data;
      wdel[wr_wt_addr]   <= wr_wgt;
    end
    if (rd_en) begin
      ring_q <= ring[rd_ring_addr];
    end
    if (wt_rd_en) begin
      wt_q <= wdel[rd_wt_addr];
    end
  end

  // control: raster counters, edge register, sequencer, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_step   <= RD_CENTRE;
      rd_live   <= 1'b0;
      plane_cnt <= '0;
      row_cnt   <= '0;
      col_cnt   <= '0;
      lin       <= '0;
      edge_len  <= EDGE_W'(EDGE_RST);
      edge_sq   <= IDX_W'(EDGE_RST * EDGE_RST);
      out_valid <= 1'b0;
    end else begin
      rd_live <= rd_en;
      // output register: load on a push, clear on a hand-over
      if ((state == S_PUSH) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_wr) begin
            edge_len  <= edge_next;
            edge_sq   <= IDX_W'(sq_next);
            plane_cnt <= '0;
            row_cnt   <= '0;
            col_cnt   <= '0;
            lin       <= '0;
          end else if (accept) begin
            if (!c_last) begin
              col_cnt <= col_cnt + 1'b1;
            end else begin
              col_cnt <= '0;
              if (!r_last) begin
                row_cnt <= row_cnt + 1'b1;
              end else begin
                row_cnt   <= '0;
                plane_cnt <= q_last ? '0 : plane_cnt + 1'b1;
              end
            end
            lin <= (c_last && r_last && q_last) ? '0 : lin + 1'b1;
            if (interior_now) begin
              rd_step <= RD_CENTRE;
              state   <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rd_step == RD_PREV) begin
            state <= S_DRAIN;
          end else begin
            rd_step <= rd_step_t'(rd_step + 3'd1);
          end
        end
        S_DRAIN: state <= S_MUL;
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_DIV;
        S_DIV: begin
          if (scale_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && (state == S_IDLE)) begin
      cur_val   <= sample.old_value;
      wgt_val   <= sample.source_weight;
      pos_slot  <= plane_cnt[0];
      pos_row   <= row_cnt;
      pos_col   <= col_cnt;
      pos_done  <= done_now;
      pos_index <= lin - edge_sq;
      nb        <= NB_W'(sample.old_value);
    end else if (rd_live) begin
      if (rd_tag == RD_CENTRE) begin
        centre <= ring_q;
      end else begin
        nb <= nb + NB_W'(ring_q);
      end
    end
    rd_tag <= rd_step;
    if (state == S_MUL) begin
      prod <= wt_q * centre;
    end
    if ((state == S_PUSH) && (!out_valid || result.ready)) begin
      out_value <= scale_value;
      out_index <= pos_index;
      out_done  <= pos_done;
    end
  end

  // stencil sum in Q16.48 into the scaling unit
  assign stencil_sum = prod + (SUM_W'(nb) <<< FRAC_W);

  jsw_scale u_scale (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_SUM),
    .sum   (stencil_sum),
    .done  (scale_done),
    .value (scale_value)
  );

endmodule

// ----- tb/sv/jacobi_3d_seven_point_sweep_top_tb.sv -----
// self-checking testbench for the streaming seven-point jacobi sweep block
`timescale 1ns / 1ps

module jacobi_3d_seven_point_sweep_top_tb;
  import jsw_pkg::*;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PLANE_WORDS   = MAX_EDGE_DEF * MAX_EDGE_DEF;
  // a short run on a 64-point grid stays on boundary points: no result may appear
  localparam int EDGE64_ITEMS  = 100;
  localparam int CUBE3_POINTS  = 27;
  localparam int CUBE3_CENTRE  = 13;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]         point_index;
    logic                     sweep_done;
  } point_update_t;

  // uniform 3x3x3 grids whose single interior update is known by hand
  typedef struct packed {
    logic [EDGE_IN_W-1:0] edge_wr;
    logic [DATA_W-1:0]    old_v;
    logic [DATA_W-1:0]    wgt;
    logic [DATA_W-1:0]    want;
  } cube_case_t;

  cube_case_t cube_cases [6] = '{
    '{7'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},  // max times max saturates high
    '{7'd0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},  // min times min saturates high
    '{7'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},  // max times min saturates low
    '{7'd2, 32'h0100_0000, 32'h0000_0000, 32'h0100_0000},  // six ones over six
    '{7'd3, 32'h0000_0001, 32'hFD00_0000, 32'h0000_0001},  // half rounds away from zero
    '{7'd2, 32'h0000_0001, 32'hF700_0000, 32'hFFFF_FFFF}   // minus half rounds away
  };

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  jsw_in_if  sample_ch ();
  jsw_out_if result_ch ();

  jacobi_3d_seven_point_sweep_top dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state: old-value ring, weight delay, raster position, edge
  logic [DATA_W-1:0] old_ring [2*PLANE_WORDS];
  logic [DATA_W-1:0] weight_plane [PLANE_WORDS];
  int unsigned       at_plane, at_row, at_col, model_edge;

  point_update_t pending_updates [$];
  int            mismatch_count = 0;
  int            send_idle, recv_idle;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("jacobi_3d_seven_point_sweep_top_tb: done, errors");
    $finish;
  end

  function automatic int ring_slot(input int unsigned pl, input int unsigned row,
                                   input int unsigned col);
    return (pl & 1) * PLANE_WORDS + row * MAX_EDGE_DEF + col;
  endfunction

  // exact divide by 6*2^24, ties away from zero, saturate to 32 bits
  function automatic logic [DATA_W-1:0] sixth_round_sat(input longint s);
    longint unsigned mag, quo;
    mag = (s < 0) ? -s : s;
    quo = (mag + (64'd3 << FRAC_W)) / (64'd6 << FRAC_W);
    if (s < 0) begin
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      return DATA_W'(64'd0 - quo);
    end
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    return DATA_W'(quo);
  endfunction

  // one raster point in: store it, advance the raster, maybe update the point a plane back
  function automatic bit advance_jacobi_point(input logic [DATA_W-1:0] cur,
                                              input logic [DATA_W-1:0] wgt,
                                              output point_update_t upd);
    int unsigned p, e, wpos;
    longint      centre, f, nb, s;
    bit          hit;
    hit  = 1'b0;
    upd  = '0;
    e    = model_edge;
    wpos = at_row * MAX_EDGE_DEF + at_col;
    if (at_plane >= 2 && at_row >= 1 && at_row + 1 < e && at_col >= 1 && at_col + 1 < e) begin
      p      = at_plane - 1;
      centre = $signed(old_ring[ring_slot(p, at_row, at_col)]);
      f      = $signed(weight_plane[wpos]);
      nb     = $signed(old_ring[ring_slot(p, at_row, at_col - 1)])
             + $signed(old_ring[ring_slot(p, at_row, at_col + 1)])
             + $signed(old_ring[ring_slot(p, at_row - 1, at_col)])
             + $signed(old_ring[ring_slot(p, at_row + 1, at_col)])
             + $signed(old_ring[ring_slot(at_plane, at_row, at_col)])
             + $signed(cur);
      s = f * centre + nb * 64'sd16777216;
      upd.new_value   = sixth_round_sat(s);
      upd.point_index = IDX_W'(p * e * e + at_row * e + at_col);
      upd.sweep_done  = (at_plane + 1 == e && at_row + 2 == e && at_col + 2 == e);
      hit = 1'b1;
    end
    old_ring[ring_slot(at_plane, at_row, at_col)] = cur;
    weight_plane[wpos] = wgt;
    if (at_col + 1 < e) begin
      at_col = at_col + 1;
    end else begin
      at_col = 0;
      if (at_row + 1 < e) begin
        at_row = at_row + 1;
      end else begin
        at_row   = 0;
        at_plane = (at_plane + 1 < e) ? at_plane + 1 : 0;
      end
    end
    return hit;
  endfunction

  // old values: extremes, zero, full range, moderate q8.24 most often
  function automatic logic [DATA_W-1:0] rand_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4, 5: return r;
      default: return {{4{r[27]}}, r[27:0]};
    endcase
  endfunction

  // source weights: same mix, moderate part kept within +/-2.0
  function automatic logic [DATA_W-1:0] rand_weight();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4, 5: return r;
      default: return {{6{r[25]}}, r[25:0]};
    endcase
  endfunction

  function automatic void set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle = 15; recv_idle = 84; end
      1: begin send_idle = 84; recv_idle = 15; end
      default: begin send_idle = 0; recv_idle = 0; end
    endcase
  endfunction

  // one sample transaction with random lead-in gap, then prediction
  task automatic send_point(input logic [DATA_W-1:0] old_v, input logic [DATA_W-1:0] wgt,
                            input bit typed, input logic [DATA_W-1:0] typed_value);
    point_update_t upd;
    if ($urandom_range(0, 99) < send_idle) begin
      sample_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.old_value     <= old_v;
    sample_ch.source_weight <= wgt;
    do @(posedge clk); while (!sample_ch.ready);
    if (advance_jacobi_point(old_v, wgt, upd)) begin
      if (typed) upd = '{typed_value, IDX_W'(CUBE3_CENTRE), 1'b1};
      pending_updates.push_back(upd);
    end
  endtask

  task automatic hold_until_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_updates.size() != 0);
  endtask

  // idle the block: drain every pending result, then let it settle
  task automatic settle_for_write();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of grid_edge; restarts the sweep
  task automatic write_edge(input logic [EDGE_IN_W-1:0] wr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_GRID_EDGE, 2'b00});
    pwdata  <= PDATA_W'(wr);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (wr < EDGE_MIN) model_edge = EDGE_MIN;
    else if (wr > MAX_EDGE_DEF) model_edge = MAX_EDGE_DEF;
    else model_edge = wr;
    at_plane = 0;
    at_row   = 0;
    at_col   = 0;
  endtask

  // result receiver with random stalls
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // compare each result transaction with the oldest pending update
  always @(posedge clk) begin
    point_update_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected result: new_value %h point_index %0d sweep_done %b",
               result_ch.new_value, result_ch.point_index, result_ch.sweep_done);
        mismatch_count++;
      end else begin
        want = pending_updates.pop_front();
        if (result_ch.new_value !== want.new_value) begin
          $error("new_value: expected %h, got %h", want.new_value, result_ch.new_value);
          mismatch_count++;
        end
        if (result_ch.point_index !== want.point_index) begin
          $error("point_index: expected %0d, got %0d", want.point_index,
                 result_ch.point_index);
          mismatch_count++;
        end
        if (result_ch.sweep_done !== want.sweep_done) begin
          $error("sweep_done: expected %b, got %b", want.sweep_done, result_ch.sweep_done);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int random_items;
    int pick;
    int count;
    int cube;
    logic [EDGE_IN_W-1:0] wr;
    rst                     <= 1'b1;
    sample_ch.valid         <= 1'b0;
    sample_ch.old_value     <= '0;
    sample_ch.source_weight <= '0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    random_items   = 0;
    model_edge     = EDGE_RESET;
    at_plane       = 0;
    at_row         = 0;
    at_col         = 0;
    set_idle_mode(0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset edge of 64: boundary points only, no result yet
    repeat (EDGE64_ITEMS) send_point(rand_value(), rand_weight(), 1'b0, '0);

    // hand-checked 3x3x3 grids, edge writes below the minimum among them
    foreach (cube_cases[i]) begin
      settle_for_write();
      write_edge(cube_cases[i].edge_wr);
      repeat (CUBE3_POINTS)
        send_point(cube_cases[i].old_v, cube_cases[i].wgt, 1'b1, cube_cases[i].want);
    end

    // random phases: small grids, partial and repeated sweeps, clamped edges
    while (random_items < RANDOM_ITEMS) begin
      settle_for_write();
      pick = $urandom_range(0, 9);
      if (pick == 0) wr = EDGE_IN_W'($urandom_range(0, 2));
      else if (pick == 1) wr = EDGE_IN_W'($urandom_range(64, 127));
      else wr = EDGE_IN_W'($urandom_range(3, 7));
      write_edge(wr);
      if (pick == 1) begin
        count = $urandom_range(40, 400);
      end else begin
        cube  = model_edge * model_edge * model_edge;
        count = cube * $urandom_range(0, 1) + $urandom_range(1, cube);
      end
      if (count > RANDOM_ITEMS - random_items) count = RANDOM_ITEMS - random_items;
      repeat (count) begin
        set_idle_mode((random_items * 3 / RANDOM_ITEMS > 2) ? 2
                                                           : random_items * 3 / RANDOM_ITEMS);
        if ($urandom_range(0, 249) == 0) hold_until_drained();
        send_point(rand_value(), rand_weight(), 1'b0, '0);
        random_items++;
      end
    end

    // oversized edge write clamps to 64: again boundary points only
    settle_for_write();
    set_idle_mode(2);
    write_edge(7'd127);
    repeat (EDGE64_ITEMS) send_point(rand_value(), rand_weight(), 1'b0, '0);

    settle_for_write();
    if (mismatch_count == 0) begin
      $display("jacobi_3d_seven_point_sweep_top_tb: done, clean");
    end else begin
      $display("jacobi_3d_seven_point_sweep_top_tb: done, errors");
    end
    $finish;
  end

endmodule
